// ===== rtl/core/obts_pkg.sv =====
// Shared constants for the one-button time setter.
`default_nettype none
package obts_pkg;

  localparam int unsigned BLINK_SHIFT = 8;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // configuration register word index (paddr[2])
  typedef enum logic {
    REG_LONG_PRESS   = 1'b0,
    REG_IDLE_TIMEOUT = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    REQ_TICK  = 1'b0,
    REQ_START = 1'b1
  } req_type_t;

  localparam logic [15:0] LONG_PRESS_RESET   = 16'd1000;
  localparam logic [15:0] IDLE_TIMEOUT_RESET = 16'd10000;
  localparam logic [15:0] PRESS_MAX          = 16'hffff;
  localparam logic [4:0]  HOUR_WRAP          = 5'd24;
  localparam logic [5:0]  MINUTE_WRAP        = 6'd60;
  localparam logic [1:0]  MASK_BOTH          = 2'b11;
  localparam logic [1:0]  MASK_HOUR          = 2'b01;
  localparam logic [1:0]  MASK_MINUTE        = 2'b10;

endpackage
`default_nettype wire

// ===== rtl/core/one_button_time_setter.sv =====
// One-button time setter: setting-mode state, key press handling and result register.
//
//  channel | direction | handshake                  | payload
//  in_     | input     | in_valid / in_stall        | req_type, key_down, start_hour, start_minute
//  out_    | output    | out_valid / out_stall      | hour_now, minute_now, refresh, show_mask,
//          |           |                            | setting_active, done_res
//  cfg     | input     | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
// One request per cycle while in_stall is low: the state update and the result are computed in one pass
// and are written into the result register when the request is accepted.
// in_stall is high only while a result is held in the result register and out_stall is high.
// Synchronous active-low reset: setting mode off, time 00:00, configuration registers at defaults.
`default_nettype none
module one_button_time_setter (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // request channel
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic                               in_req_type,
  input  wire logic                               in_key_down,
  input  wire logic [4:0]                         in_start_hour,
  input  wire logic [5:0]                         in_start_minute,
  // result channel
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [4:0]                              out_hour_now,
  output logic [5:0]                              out_minute_now,
  output logic                                    out_refresh,
  output logic [1:0]                              out_show_mask,
  output logic                                    out_setting_active,
  output logic                                    out_done_res,
  // configuration
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [obts_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire logic [obts_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [obts_pkg::CFG_DATA_W-1:0]         prdata,
  output logic                                    pready
);

  // configuration registers
  logic [15:0] long_press_r;
  logic [15:0] idle_timeout_r;
  logic        cfg_wr;
  obts_pkg::cfg_reg_t cfg_sel;

  // setting-mode state
  logic        active_r,     active_nxt;
  logic [4:0]  hour_r,       hour_nxt;
  logic [5:0]  minute_r,     minute_nxt;
  logic [15:0] idle_r,       idle_nxt;
  logic [15:0] press_r,      press_nxt;
  logic        latched_r,    latched_nxt;
  logic        min_sel_r,    min_sel_nxt;
  logic [1:0]  blink_r,      blink_nxt;

  // result register
  logic        out_valid_r;
  logic [4:0]  res_hour_r;
  logic [5:0]  res_minute_r;
  logic        res_refresh_r, res_refresh_nxt;
  logic [1:0]  res_mask_r,    res_mask_nxt;
  logic        res_done_r,    res_done_nxt;

  logic        in_fire;

  // working values of the tick path
  logic        release_key;
  logic        long_press;
  logic        bump;
  logic        sel_t;
  logic [1:0]  blink_t;
  logic [15:0] idle_t;
  logic        latched_t;
  logic [15:0] press_t;
  logic [4:0]  hour_inc;
  logic [5:0]  minute_inc;
  logic [16:0] idle_next_wide;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_sel = obts_pkg::cfg_reg_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_press_r   <= obts_pkg::LONG_PRESS_RESET;
      idle_timeout_r <= obts_pkg::IDLE_TIMEOUT_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        obts_pkg::REG_LONG_PRESS:   long_press_r   <= pwdata[15:0];
        obts_pkg::REG_IDLE_TIMEOUT: idle_timeout_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      obts_pkg::REG_LONG_PRESS:   prdata = {16'd0, long_press_r};
      obts_pkg::REG_IDLE_TIMEOUT: prdata = {16'd0, idle_timeout_r};
      default:                    prdata = '0;
    endcase
  end

  // accept while the result register is free or being drained
  assign in_stall = out_valid_r & out_stall;
  assign in_fire  = in_valid & ~in_stall;

  always_comb begin
    release_key = ~in_key_down & latched_r;
    long_press  = press_r > long_press_r;
    bump        = release_key & ~long_press;

    sel_t   = (release_key & long_press) ? ~min_sel_r : min_sel_r;
    blink_t = (release_key & long_press) ? obts_pkg::MASK_BOTH : blink_r;
    idle_t  = bump ? 16'd0 : idle_r;

    hour_inc   = hour_r + 5'd1;
    if (hour_inc >= obts_pkg::HOUR_WRAP) hour_inc = 5'd0;
    minute_inc = minute_r + 6'd1;
    if (minute_inc >= obts_pkg::MINUTE_WRAP) minute_inc = 6'd0;

    latched_t = release_key ? 1'b0 : latched_r;
    press_t   = press_r;
    if (in_key_down && !latched_t) begin
      latched_t = 1'b1;
      press_t   = 16'd0;
    end

    idle_next_wide = {1'b0, idle_t} + 17'd1;

    // defaults: idle tick, nothing changes
    active_nxt      = active_r;
    hour_nxt        = hour_r;
    minute_nxt      = minute_r;
    idle_nxt        = idle_r;
    press_nxt       = press_r;
    latched_nxt     = latched_r;
    min_sel_nxt     = min_sel_r;
    blink_nxt       = blink_r;
    res_refresh_nxt = 1'b0;
    res_mask_nxt    = 2'b00;
    res_done_nxt    = 1'b0;

    if (in_req_type == obts_pkg::REQ_START) begin
      active_nxt      = 1'b1;
      hour_nxt        = in_start_hour;
      minute_nxt      = in_start_minute;
      idle_nxt        = 16'd0;
      press_nxt       = 16'd0;
      latched_nxt     = 1'b0;
      min_sel_nxt     = 1'b0;
      blink_nxt       = obts_pkg::MASK_BOTH;
      res_refresh_nxt = 1'b1;
      res_mask_nxt    = obts_pkg::MASK_BOTH;
    end else if (active_r) begin
      if (bump && min_sel_r)  minute_nxt = minute_inc;
      if (bump && !min_sel_r) hour_nxt   = hour_inc;
      min_sel_nxt = sel_t;
      latched_nxt = latched_t;
      blink_nxt   = blink_t;
      if (idle_t[obts_pkg::BLINK_SHIFT-1:0] == '0) begin
        res_refresh_nxt = 1'b1;
        res_mask_nxt    = blink_t;
        blink_nxt       = blink_t ^ (sel_t ? obts_pkg::MASK_MINUTE : obts_pkg::MASK_HOUR);
      end
      press_nxt = (latched_t && press_t != obts_pkg::PRESS_MAX) ? press_t + 16'd1 : press_t;
      idle_nxt  = idle_next_wide[15:0];
      if (idle_next_wide >= {1'b0, idle_timeout_r}) begin
        active_nxt   = 1'b0;
        res_done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= 1'b0;
      hour_r    <= 5'd0;
      minute_r  <= 6'd0;
      idle_r    <= 16'd0;
      press_r   <= 16'd0;
      latched_r <= 1'b0;
      min_sel_r <= 1'b0;
      blink_r   <= obts_pkg::MASK_BOTH;
    end else if (in_fire) begin
      active_r  <= active_nxt;
      hour_r    <= hour_nxt;
      minute_r  <= minute_nxt;
      idle_r    <= idle_nxt;
      press_r   <= press_nxt;
      latched_r <= latched_nxt;
      min_sel_r <= min_sel_nxt;
      blink_r   <= blink_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_hour_r    <= hour_nxt;
      res_minute_r  <= minute_nxt;
      res_refresh_r <= res_refresh_nxt;
      res_mask_r    <= res_mask_nxt;
      res_done_r    <= res_done_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_hour_now       = res_hour_r;
  assign out_minute_now     = res_minute_r;
  assign out_refresh        = res_refresh_r;
  assign out_show_mask      = res_mask_r;
  assign out_setting_active = active_r;
  assign out_done_res       = res_done_r;

  // a show mask only comes with a refresh
  a_mask_needs_refresh: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_refresh |-> out_show_mask == 2'b00)
    else $error("show_mask set without refresh");

  // done means setting mode just ended
  a_done_ends_setting: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_setting_active)
    else $error("done with setting mode still active");

  // an accepted request always leaves a result behind
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted request produced no result");

  // a start request always enters setting mode
  a_start_activates: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_req_type |=> out_setting_active && out_refresh)
    else $error("start request did not enter setting mode");

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the one-button time setter: directed edits, timeouts, random sessions.
`timescale 1ns / 1ps
module tb;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SHOWN_MISMATCHES = 10;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic       refresh;
    logic [1:0] mask;
    logic       active;
    logic       done;
  } display_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  wire         in_stall;
  logic        in_req_type = obts_pkg::REQ_TICK;
  logic        in_key_down = 1'b0;
  logic [4:0]  in_start_hour = '0;
  logic [5:0]  in_start_minute = '0;
  wire         out_valid;
  logic        out_stall = 1'b0;
  wire  [4:0]  out_hour_now;
  wire  [5:0]  out_minute_now;
  wire         out_refresh;
  wire  [1:0]  out_show_mask;
  wire         out_setting_active;
  wire         out_done_res;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [obts_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [obts_pkg::CFG_DATA_W-1:0] pwdata = '0;
  wire  [obts_pkg::CFG_DATA_W-1:0] prdata;
  wire         pready;

  // mirror of the setter state
  logic [15:0] long_press_cfg = obts_pkg::LONG_PRESS_RESET;
  logic [15:0] idle_timeout_cfg = obts_pkg::IDLE_TIMEOUT_RESET;
  logic        set_mode = 1'b0;
  logic [4:0]  hour_val = '0;
  logic [5:0]  minute_val = '0;
  logic [15:0] idle_ticks = '0;
  logic [15:0] held_ticks = '0;
  logic        key_held = 1'b0;
  logic        editing_minute = 1'b0;
  logic [1:0]  blink_bits = obts_pkg::MASK_BOTH;

  display_t    expected_displays[$];
  int unsigned mismatch_count = 0;
  int unsigned requests_sent = 0;
  int unsigned cycles_run = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;

  one_button_time_setter DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_req_type(in_req_type), .in_key_down(in_key_down),
    .in_start_hour(in_start_hour), .in_start_minute(in_start_minute),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_hour_now(out_hour_now), .out_minute_now(out_minute_now),
    .out_refresh(out_refresh), .out_show_mask(out_show_mask),
    .out_setting_active(out_setting_active), .out_done_res(out_done_res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) out_stall <= ($urandom_range(0, 99) < stall_pct);

  function automatic void note_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= SHOWN_MISMATCHES) $display("MISMATCH: %s", msg);
  endfunction

  function automatic string describe(display_t d);
    return $sformatf("%0d:%0d refresh=%0b mask=%0d active=%0b done=%0b",
                     d.hour, d.minute, d.refresh, d.mask, d.active, d.done);
  endfunction

  // Advance the setter by one accepted request and queue the display it produces.
  function automatic void step_time_setter(logic rt, logic key, logic [4:0] hr,
                                           logic [5:0] mn);
    display_t   d;
    logic [4:0] nh;
    logic [5:0] nm;
    logic [16:0] nxt;
    d = '0;
    if (rt == obts_pkg::REQ_START) begin
      hour_val = hr;
      minute_val = mn;
      idle_ticks = '0;
      held_ticks = '0;
      key_held = 1'b0;
      editing_minute = 1'b0;
      blink_bits = obts_pkg::MASK_BOTH;
      set_mode = 1'b1;
      d.refresh = 1'b1;
      d.mask = obts_pkg::MASK_BOTH;
    end else if (set_mode) begin
      if (!key && key_held) begin
        if (held_ticks > long_press_cfg) begin
          editing_minute = !editing_minute;
          blink_bits = obts_pkg::MASK_BOTH;
        end else begin
          if (editing_minute) begin
            nm = minute_val + 6'd1;
            minute_val = (nm >= obts_pkg::MINUTE_WRAP) ? 6'd0 : nm;
          end else begin
            nh = hour_val + 5'd1;
            hour_val = (nh >= obts_pkg::HOUR_WRAP) ? 5'd0 : nh;
          end
          idle_ticks = '0;
        end
        key_held = 1'b0;
      end
      if (key && !key_held) begin
        key_held = 1'b1;
        held_ticks = '0;
      end
      if ((idle_ticks & ((16'd1 << obts_pkg::BLINK_SHIFT) - 16'd1)) == 16'd0) begin
        d.refresh = 1'b1;
        d.mask = blink_bits;
        blink_bits = blink_bits ^ (editing_minute ? obts_pkg::MASK_MINUTE
                                                  : obts_pkg::MASK_HOUR);
      end
      if (key_held && held_ticks != obts_pkg::PRESS_MAX) held_ticks = held_ticks + 16'd1;
      nxt = {1'b0, idle_ticks} + 17'd1;
      if (nxt >= {1'b0, idle_timeout_cfg}) begin
        set_mode = 1'b0;
        d.done = 1'b1;
      end
      idle_ticks = nxt[15:0];
    end
    d.hour = hour_val;
    d.minute = minute_val;
    d.active = set_mode;
    expected_displays.push_back(d);
  endfunction

  always @(posedge clk) begin : check_results
    display_t seen;
    display_t want;
    cycles_run++;
    if (cycles_run > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else if (rst_n && out_valid && !out_stall) begin
      seen = {out_hour_now, out_minute_now, out_refresh, out_show_mask,
              out_setting_active, out_done_res};
      if (expected_displays.size() == 0) begin
        note_mismatch($sformatf("unexpected result %s", describe(seen)));
      end else begin
        want = expected_displays.pop_front();
        if (seen !== want)
          note_mismatch($sformatf("expected %s got %s", describe(want), describe(seen)));
      end
    end
  end

  task automatic send_request(logic rt, logic key, logic [4:0] hr, logic [5:0] mn);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= rt;
    in_key_down <= key;
    in_start_hour <= hr;
    in_start_minute <= mn;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    step_time_setter(rt, key, hr, mn);
    requests_sent++;
  endtask

  // tick payload time fields are don't-care, so they get random bits
  task automatic send_tick(logic key);
    send_request(obts_pkg::REQ_TICK, key, 5'($urandom_range(0, 31)),
                 6'($urandom_range(0, 63)));
  endtask

  task automatic press_key(int unsigned hold, int unsigned gap);
    repeat (hold) send_tick(1'b1);
    repeat (gap) send_tick(1'b0);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_displays.size() != 0);
  endtask

  task automatic cfg_read(obts_pkg::cfg_reg_t idx, logic [15:0] want);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {16'd0, want})
      note_mismatch($sformatf("%s read %h expected %h", idx.name(), prdata, want));
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // psel stays up into the read-back setup
  task automatic cfg_write(obts_pkg::cfg_reg_t idx, logic [15:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == obts_pkg::REG_LONG_PRESS) long_press_cfg = val;
    else idle_timeout_cfg = val;
    cfg_read(idx, val);
  endtask

  task automatic set_timing(logic [15:0] long_press, logic [15:0] timeout);
    wait_drained();
    cfg_write(obts_pkg::REG_LONG_PRESS, long_press);
    cfg_write(obts_pkg::REG_IDLE_TIMEOUT, timeout);
  endtask

  task automatic test_reset_values();
    cfg_read(obts_pkg::REG_LONG_PRESS, obts_pkg::LONG_PRESS_RESET);
    cfg_read(obts_pkg::REG_IDLE_TIMEOUT, obts_pkg::IDLE_TIMEOUT_RESET);
    send_tick(1'b1);
    send_tick(1'b0);
  endtask

  task automatic test_field_editing();
    set_timing(16'd2, 16'd65535);
    send_request(obts_pkg::REQ_START, 1'b0, 5'd23, 6'd59);
    press_key(1, 1);   // hour 23 wraps to 0
    press_key(3, 1);   // long press: minutes selected
    press_key(1, 1);   // minute 59 wraps to 0
    // restart while active with out-of-range time
    send_request(obts_pkg::REQ_START, 1'b1, 5'd31, 6'd63);
    press_key(1, 1);
    press_key(3, 1);
    press_key(1, 1);
  endtask

  task automatic test_timeouts();
    set_timing(16'd2, 16'd1);
    send_request(obts_pkg::REQ_START, 1'b0, 5'd0, 6'd0);
    send_tick(1'b1);
    send_tick(1'b0);
    set_timing(16'd65535, 16'd0);
    send_request(obts_pkg::REQ_START, 1'b0, 5'd12, 6'd30);
    send_tick(1'b0);
  endtask

  task automatic test_random_sessions(logic [15:0] long_press, logic [15:0] timeout,
                                      int unsigned idle_pct, int unsigned stall,
                                      int unsigned count);
    int unsigned stop_at;
    int unsigned hold;
    int unsigned cap;
    logic [4:0]  hr;
    logic [5:0]  mn;
    set_timing(long_press, timeout);
    send_idle_pct = idle_pct;
    stall_pct = stall;
    stop_at = requests_sent + count;
    cap = (idle_timeout_cfg > 300) ? 320 : idle_timeout_cfg + 20;
    while (requests_sent < stop_at) begin
      if ($urandom_range(0, 14) == 0) wait_drained();
      if ($urandom_range(0, 99) < 80) begin
        hr = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 23));
        mn = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 59));
        send_request(obts_pkg::REQ_START, 1'($urandom_range(0, 1)), hr, mn);
        repeat ($urandom_range(1, 10)) begin
          if ($urandom_range(0, 2) == 0 && long_press_cfg < 16'd16)
            hold = long_press_cfg + 1 + $urandom_range(0, 3);
          else
            hold = $urandom_range(1, 6);
          press_key(hold, $urandom_range(1, 4));
        end
        // occasionally sit long enough to blink and time out
        repeat (($urandom_range(0, 3) == 0) ? $urandom_range(0, cap) : $urandom_range(0, 8))
          send_tick(1'b0);
      end else begin
        repeat ($urandom_range(1, 8))
          send_request(($urandom_range(0, 5) == 0) ? obts_pkg::REQ_START : obts_pkg::REQ_TICK,
                       1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)),
                       6'($urandom_range(0, 63)));
      end
    end
    send_idle_pct = 0;
    stall_pct = 0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_field_editing();
    test_timeouts();
    test_random_sessions(16'd4, 16'd40, 0, 0, 390);
    test_random_sessions(16'd0, 16'd270, 85, 0, 390);
    test_random_sessions(16'd65535, 16'd300, 0, 85, 390);
    test_random_sessions(16'd9, 16'd65535, 19, 19, 390);
    wait_drained();
    repeat (4) @(posedge clk);
    mismatch_count += expected_displays.size();
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
